>>> design/fpa_pkg.sv
package fpa_pkg;
    localparam int ExpW = 8;
    localparam int FracW = 23;
    localparam int SigW = 27;
    localparam int HiddenPos = 26;
    localparam logic [ExpW-1:0] ExpMax = 8'd254;
    localparam logic [30:0] InfWord = 31'h7F800000;
endpackage

>>> design/fp32_positive_adder_unit.sv
// Positive single-precision adder. One operand pair enters per cycle on s_axis
// (tdata bits: exponent_a[7:0], fraction_a[30:8], exponent_b[38:31],
// fraction_b[61:39]); each result leaves on m_axis after the stages below (tdata bits:
// sum_word[30:0], overflow[31]). Four register stages: swap and zero check,
// alignment shift with sticky, add and normalize, round and pack. A stall holds
// every stage; the pipeline keeps one pair per cycle while m_axis_tready is high.
module fp32_positive_adder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // exponent_a, fraction_a, exponent_b, fraction_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // sum_word, overflow
);
    localparam int EW = fpa_pkg::ExpW;
    localparam int FW = fpa_pkg::FracW;
    localparam int SW = fpa_pkg::SigW;

    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic [EW-1:0] ea, eb;
    logic [FW-1:0] fa, fb;
    assign ea = s_axis_tdata[7:0];
    assign fa = s_axis_tdata[30:8];
    assign eb = s_axis_tdata[38:31];
    assign fb = s_axis_tdata[61:39];

    // stage 1
    logic v1_reg, sp1_reg, ov1_reg;
    logic [30:0] w1_reg;
    logic [EW-1:0] e1_reg, d1_reg;
    logic [FW-1:0] fh1_reg, fl1_reg;
    // stage 2
    logic v2_reg, sp2_reg, ov2_reg;
    logic [30:0] w2_reg;
    logic [EW-1:0] e2_reg;
    logic [SW-1:0] ma2_reg, mb2_reg;
    // stage 3
    logic v3_reg, sp3_reg, ov3_reg;
    logic [30:0] w3_reg;
    logic [EW:0] e3_reg;
    logic [SW-1:0] m3_reg;
    // stage 4
    logic v4_reg;
    logic [31:0] out_reg;

    logic swap;
    logic s1_sp, s1_ov;
    logic [30:0] s1_w;
    assign swap = ea < eb;
    always_comb
    begin
        s1_sp = 1'b1;
        s1_ov = 1'b0;
        s1_w = '0;
        if (ea > fpa_pkg::ExpMax || eb > fpa_pkg::ExpMax)
        begin
            s1_w = fpa_pkg::InfWord;
            s1_ov = 1'b1;
        end
        else if (ea == '0 && eb == '0)
            s1_w = '0;
        else if (ea == '0)
            s1_w = {eb, fb};
        else if (eb == '0)
            s1_w = {ea, fa};
        else
            s1_sp = 1'b0;
    end

    logic [SW-1:0] mbs, mbsh, lostm;
    logic [SW-1:0] s2_mb;
    always_comb
    begin
        mbs = {1'b1, fl1_reg, 3'b000};
        mbsh = mbs >> d1_reg;
        lostm = (SW'(1) << d1_reg[4:0]) - SW'(1);
        if (d1_reg == '0)
            s2_mb = mbs;
        else if (d1_reg > EW'(fpa_pkg::HiddenPos))
            s2_mb = SW'(1);
        else
            s2_mb = mbsh | SW'((mbs & lostm) != '0);
    end

    logic [SW:0] sum;
    logic [SW-1:0] s3_m;
    logic [EW:0] s3_e;
    assign sum = {1'b0, ma2_reg} + {1'b0, mb2_reg};
    always_comb
    begin
        s3_e = {1'b0, e2_reg};
        s3_m = sum[SW-1:0];
        if (sum[SW])
        begin
            s3_m = sum[SW:1];
            s3_e = s3_e + 1'b1;
        end
    end

    logic [SW:0] rnd;
    logic [EW:0] e4;
    logic [SW-1:0] m4;
    logic [31:0] s4_out;
    always_comb
    begin
        rnd = {1'b0, m3_reg[SW-1:3], 3'b000};
        if (m3_reg[2] && (m3_reg[1:0] != 2'b00 || m3_reg[3]))
            rnd = rnd + (SW+1)'(8);
        e4 = e3_reg;
        m4 = rnd[SW-1:0];
        if (rnd[SW])
        begin
            m4 = rnd[SW:1];
            e4 = e3_reg + 1'b1;
        end
        if (sp3_reg)
            s4_out = {ov3_reg, w3_reg};
        else if (e4 > {1'b0, fpa_pkg::ExpMax})
            s4_out = {1'b1, fpa_pkg::InfWord};
        else
            s4_out = {1'b0, e4[EW-1:0], m4[SW-2:3]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp1_reg <= s1_sp;
            ov1_reg <= s1_ov;
            w1_reg <= s1_w;
            e1_reg <= swap ? eb : ea;
            d1_reg <= swap ? eb - ea : ea - eb;
            fh1_reg <= swap ? fb : fa;
            fl1_reg <= swap ? fa : fb;
            sp2_reg <= sp1_reg;
            ov2_reg <= ov1_reg;
            w2_reg <= w1_reg;
            e2_reg <= e1_reg;
            ma2_reg <= {1'b1, fh1_reg, 3'b000};
            mb2_reg <= s2_mb;
            sp3_reg <= sp2_reg;
            ov3_reg <= ov2_reg;
            w3_reg <= w2_reg;
            e3_reg <= s3_e;
            m3_reg <= s3_m;
            out_reg <= s4_out;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata = out_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[31] |-> m_axis_tdata[30:0] == fpa_pkg::InfWord)
        else $error("overflow without infinity");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && v3_reg |=> m_axis_tvalid)
        else $error("request lost in pipeline");
endmodule
